>>> design/rpcv_pkg.sv
// ----------------------------------------------------------------------------
// rpcv_pkg
// Types, codes and helpers shared by the call frame validator modules.
// ----------------------------------------------------------------------------
package rpcv_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC    = 4'd0,
    PH_NAMELEN  = 4'd1,
    PH_NAME     = 4'd2,
    PH_ARGCOUNT = 4'd3,
    PH_TAG      = 4'd4,
    PH_BOOL     = 4'd5,
    PH_INT      = 4'd6,
    PH_FLOAT    = 4'd7,
    PH_STRLEN   = 4'd8,
    PH_STR      = 4'd9,
    PH_BLOBLEN  = 4'd10,
    PH_BLOB     = 4'd11,
    PH_DONE     = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_NAME     = 3'd2,
    ERR_ARGS     = 3'd3,
    ERR_TAG      = 3'd4,
    ERR_PAYLOAD  = 3'd5,
    ERR_TRUNC    = 3'd6,
    ERR_TRAILING = 3'd7
  } err_t;

  localparam logic [7:0] TAG_NULL  = 8'd0;
  localparam logic [7:0] TAG_BOOL  = 8'd1;
  localparam logic [7:0] TAG_INT   = 8'd2;
  localparam logic [7:0] TAG_FLOAT = 8'd3;
  localparam logic [7:0] TAG_STR   = 8'd4;
  localparam logic [7:0] TAG_BLOB  = 8'd5;

  localparam logic [7:0] REG_MAGIC       = 8'd0;
  localparam logic [7:0] REG_MAX_NAME    = 8'd1;
  localparam logic [7:0] REG_MAX_ARGS    = 8'd2;
  localparam logic [7:0] REG_MAX_PAYLOAD = 8'd3;

  localparam logic [31:0] MAGIC_RESET       = 32'h3143_5052;
  localparam logic [15:0] MAX_NAME_RESET    = 16'd256;
  localparam logic [15:0] MAX_ARGS_RESET    = 16'd1024;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [15:0] arg_index;
    logic [63:0] field_value;
    logic        field_complete;
    logic        frame_done;
    logic        frame_ok;
    logic [2:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] max_name_length;
    logic [15:0] max_arg_count;
    logic [31:0] max_payload_length;
  } cfg_t;

  function automatic logic [3:0] field_len(phase_t ph);
    logic [3:0] len;
    unique case (ph) inside
      PH_MAGIC, PH_STRLEN, PH_BLOBLEN: len = 4'd4;
      PH_NAMELEN, PH_ARGCOUNT:         len = 4'd2;
      PH_INT, PH_FLOAT:                len = 4'd8;
      default:                         len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

>>> design/rpcv_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpcv_cfg_regs
// Configuration register file: magic word and the three limits.
// ----------------------------------------------------------------------------
module rpcv_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output rpcv_pkg::cfg_t cfg
);
  import rpcv_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word         <= MAGIC_RESET;
      cfg.max_name_length    <= MAX_NAME_RESET;
      cfg.max_arg_count      <= MAX_ARGS_RESET;
      cfg.max_payload_length <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAGIC:       cfg.magic_word         <= cfg_data;
        REG_MAX_NAME:    cfg.max_name_length    <= cfg_data[15:0];
        REG_MAX_ARGS:    cfg.max_arg_count      <= cfg_data[15:0];
        REG_MAX_PAYLOAD: cfg.max_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/rpcv_in_stage.sv
// ----------------------------------------------------------------------------
// rpcv_in_stage
// Input register: holds one item until the parser takes it.
// ----------------------------------------------------------------------------
module rpcv_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpcv_pkg::in_item_t in_data,
  output logic              item_valid,
  output rpcv_pkg::in_item_t item,
  input  logic              item_take
);
  import rpcv_pkg::*;

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

>>> design/rpcv_parser.sv
// ----------------------------------------------------------------------------
// rpcv_parser
// Per-byte frame parser: parse state, one-step update and result register.
// ----------------------------------------------------------------------------
module rpcv_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  rpcv_pkg::in_item_t  item,
  output logic               item_take,
  input  rpcv_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output rpcv_pkg::out_item_t out_data
);
  import rpcv_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  byte_in_field, byte_in_field_next;
  logic [63:0] field_acc, field_acc_next;
  logic [31:0] bytes_rem, bytes_rem_next;
  logic [15:0] args_rem, args_rem_next;
  logic [15:0] cur_arg, cur_arg_next;
  logic [2:0]  cur_tag, cur_tag_next;
  err_t        first_err, first_err_next;

  logic [7:0]  b;
  logic [3:0]  len;
  logic [63:0] fv_full;
  logic        in_field;
  logic        field_done;
  logic [31:0] rem_dec;
  logic        do_next_arg;
  logic        do_fail;
  err_t        fail_code;
  out_item_t   result;

  assign item_take = item_valid && (!out_valid || out_ready);

  assign b        = item.in_byte;
  assign len      = field_len(phase);
  assign in_field = (phase < PH_DONE) && (len != 4'd0);
  assign rem_dec  = (bytes_rem != 32'd0) ? bytes_rem - 32'd1 : bytes_rem;

  always_comb begin
    fv_full = field_acc;
    fv_full[{byte_in_field, 3'b000} +: 8] = b;
  end

  assign field_done = in_field && (({1'b0, byte_in_field} + 4'd1) >= len);

  // next state
  always_comb begin
    phase_next         = phase;
    byte_in_field_next = byte_in_field;
    field_acc_next     = field_acc;
    bytes_rem_next     = bytes_rem;
    args_rem_next      = args_rem;
    cur_arg_next       = cur_arg;
    cur_tag_next       = cur_tag;
    first_err_next     = first_err;
    do_next_arg        = 1'b0;
    do_fail            = 1'b0;
    fail_code          = ERR_NONE;

    if (phase >= PH_DONE) begin
      if (first_err == ERR_NONE) begin
        first_err_next = ERR_TRAILING;
      end
      phase_next = PH_DONE;
    end else if (in_field) begin
      if (field_done) begin
        field_acc_next     = '0;
        byte_in_field_next = '0;
        unique case (phase) inside
          PH_MAGIC: begin
            if (fv_full[31:0] != cfg.magic_word) begin
              do_fail   = 1'b1;
              fail_code = ERR_MAGIC;
            end else begin
              phase_next = PH_NAMELEN;
            end
          end
          PH_NAMELEN: begin
            if (fv_full[15:0] > cfg.max_name_length) begin
              do_fail   = 1'b1;
              fail_code = ERR_NAME;
            end else if (fv_full[15:0] == 16'd0) begin
              phase_next = PH_ARGCOUNT;
            end else begin
              bytes_rem_next = {16'd0, fv_full[15:0]};
              phase_next     = PH_NAME;
            end
          end
          PH_ARGCOUNT: begin
            if (fv_full[15:0] > cfg.max_arg_count) begin
              do_fail   = 1'b1;
              fail_code = ERR_ARGS;
            end else if (fv_full[15:0] == 16'd0) begin
              phase_next = PH_DONE;
            end else begin
              args_rem_next = fv_full[15:0];
              phase_next    = PH_TAG;
            end
          end
          PH_INT, PH_FLOAT: begin
            do_next_arg = 1'b1;
          end
          PH_STRLEN, PH_BLOBLEN: begin
            if (fv_full[31:0] > cfg.max_payload_length) begin
              do_fail   = 1'b1;
              fail_code = ERR_PAYLOAD;
            end else if (fv_full[31:0] == 32'd0) begin
              do_next_arg = 1'b1;
            end else begin
              bytes_rem_next = fv_full[31:0];
              phase_next     = (phase == PH_STRLEN) ? PH_STR : PH_BLOB;
            end
          end
          default: ;
        endcase
      end else begin
        field_acc_next     = fv_full;
        byte_in_field_next = byte_in_field + 3'd1;
      end
    end else begin
      unique case (phase) inside
        PH_NAME: begin
          bytes_rem_next = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_next = PH_ARGCOUNT;
          end
        end
        PH_TAG: begin
          unique case (b)
            TAG_NULL: begin
              cur_tag_next = 3'd0;
              do_next_arg  = 1'b1;
            end
            TAG_BOOL: begin
              cur_tag_next = 3'd1;
              phase_next   = PH_BOOL;
            end
            TAG_INT: begin
              cur_tag_next = 3'd2;
              phase_next   = PH_INT;
            end
            TAG_FLOAT: begin
              cur_tag_next = 3'd3;
              phase_next   = PH_FLOAT;
            end
            TAG_STR: begin
              cur_tag_next = 3'd4;
              phase_next   = PH_STRLEN;
            end
            TAG_BLOB: begin
              cur_tag_next = 3'd5;
              phase_next   = PH_BLOBLEN;
            end
            default: begin
              do_fail   = 1'b1;
              fail_code = ERR_TAG;
            end
          endcase
        end
        PH_BOOL: begin
          do_next_arg = 1'b1;
        end
        PH_STR, PH_BLOB: begin
          bytes_rem_next = rem_dec;
          if (rem_dec == 32'd0) begin
            do_next_arg = 1'b1;
          end
        end
        default: begin
          do_fail   = 1'b1;
          fail_code = ERR_NONE;
        end
      endcase
    end

    if (do_next_arg) begin
      cur_arg_next = cur_arg + 16'd1;
      if (args_rem <= 16'd1) begin
        args_rem_next = '0;
        phase_next    = PH_DONE;
      end else begin
        args_rem_next = args_rem - 16'd1;
        phase_next    = PH_TAG;
      end
    end

    if (do_fail) begin
      if (first_err == ERR_NONE) begin
        first_err_next = fail_code;
      end
      phase_next = PH_DONE;
    end

    if (item.end_of_message && (phase_next != PH_DONE) && (first_err_next == ERR_NONE)) begin
      first_err_next = ERR_TRUNC;
    end
  end

  // result fields
  always_comb begin
    result.byte_role      = (phase >= PH_DONE) ? PH_DONE : phase;
    result.arg_index      = cur_arg;
    result.field_value    = field_done ? fv_full : 64'd0;
    result.field_complete = field_done;
    result.frame_done     = item.end_of_message;
    result.frame_ok       = item.end_of_message && (first_err_next == ERR_NONE);
    result.error_code     = first_err_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (item_take && item.end_of_message)) begin
      phase         <= PH_MAGIC;
      byte_in_field <= '0;
      field_acc     <= '0;
      bytes_rem     <= '0;
      args_rem      <= '0;
      cur_arg       <= '0;
      cur_tag       <= '0;
      first_err     <= ERR_NONE;
    end else if (item_take) begin
      phase         <= phase_next;
      byte_in_field <= byte_in_field_next;
      field_acc     <= field_acc_next;
      bytes_rem     <= bytes_rem_next;
      args_rem      <= args_rem_next;
      cur_arg       <= cur_arg_next;
      cur_tag       <= cur_tag_next;
      first_err     <= first_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data <= result;
    end
  end

endmodule

>>> design/rpc_call_frame_validator_top.sv
// ----------------------------------------------------------------------------
// rpc_call_frame_validator_top
// Byte-serial call frame validator with role tagging and verdict per message.
// ----------------------------------------------------------------------------
// Path: input register, one parse pass, then result register for each byte.
// Throughput: 1 byte per cycle while out_ready stays high.
// Reset: parse state cleared to the magic phase, registers to their defaults.
// Parse state also returns to reset after each byte marked end_of_message.
module rpc_call_frame_validator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpcv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rpcv_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rpcv_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     item_take;

  rpcv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpcv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rpcv_parser u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_ok |-> out_data.frame_done && out_data.error_code == ERR_NONE)
    else $error("frame_ok with error or without frame_done");

  a_reject_coded: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done && !out_data.frame_ok |-> out_data.error_code != ERR_NONE)
    else $error("reject without error code");

  a_field_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.field_complete |->
      (out_data.byte_role == PH_MAGIC || out_data.byte_role == PH_NAMELEN ||
       out_data.byte_role == PH_ARGCOUNT || out_data.byte_role == PH_INT ||
       out_data.byte_role == PH_FLOAT || out_data.byte_role == PH_STRLEN ||
       out_data.byte_role == PH_BLOBLEN))
    else $error("field completed on a non-field byte");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    item_take |=> out_valid)
    else $error("taken item produced no result");

endmodule

>>> tb/tb_rpc_call_frame_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpc_call_frame_validator_top
// Self-checking bench for the call frame validator. A short table of
// hand-built messages comes first. Random frames follow under several register
// settings, mostly well-formed with random content, some truncated, padded,
// corrupted or pure noise. Each result is checked against its table row's want
// or a byte-level parser model in the bench. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_rpc_call_frame_validator_top;
  import rpcv_pkg::*;

  localparam int     N_DIRECTED    = 46;
  localparam int     N_PHASES      = 7;
  localparam int     ITEMS_PER_SET = 160;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     MAX_REPORTS   = 200;
  localparam longint WATCHDOG_NS   = 64'd16_000_000;

  typedef struct packed {
    logic [7:0] b;
    logic       eom;
    logic       known;
    out_item_t  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  // register mirror
  logic [31:0] exp_magic;
  logic [15:0] lim_name;
  logic [15:0] lim_args;
  logic [31:0] lim_payload;

  // parser model state
  phase_t      frame_phase;
  logic [2:0]  field_pos;
  logic [63:0] field_acc;
  logic [31:0] body_left;
  logic [15:0] args_left;
  logic [15:0] arg_num;
  err_t        sticky_err;

  out_item_t   reports_due[$];
  logic [7:0]  frame_bytes[$];
  int          bytes_sent  = 0;
  int          frames_sent = 0;
  int          frames_ok   = 0;
  int          frames_bad  = 0;
  int          mismatches  = 0;
  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;

  rpc_call_frame_validator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- parser model ----------------

  function automatic void clear_parser();
    frame_phase = PH_MAGIC;
    field_pos   = '0;
    field_acc   = '0;
    body_left   = '0;
    args_left   = '0;
    arg_num     = '0;
    sticky_err  = ERR_NONE;
  endfunction

  function automatic void fail_with(input err_t code);
    if (sticky_err == ERR_NONE) sticky_err = code;
    frame_phase = PH_DONE;
  endfunction

  function automatic void advance_arg();
    arg_num = arg_num + 16'd1;
    if (args_left <= 16'd1) begin
      args_left   = '0;
      frame_phase = PH_DONE;
    end else begin
      args_left   = args_left - 16'd1;
      frame_phase = PH_TAG;
    end
  endfunction

  function automatic void close_field(input logic [63:0] v);
    case (frame_phase) inside
      PH_MAGIC: begin
        if (v[31:0] != exp_magic) fail_with(ERR_MAGIC);
        else frame_phase = PH_NAMELEN;
      end
      PH_NAMELEN: begin
        if (v > lim_name) fail_with(ERR_NAME);
        else if (v == 0) frame_phase = PH_ARGCOUNT;
        else begin
          body_left   = v[31:0];
          frame_phase = PH_NAME;
        end
      end
      PH_ARGCOUNT: begin
        if (v > lim_args) fail_with(ERR_ARGS);
        else if (v == 0) frame_phase = PH_DONE;
        else begin
          args_left   = v[15:0];
          frame_phase = PH_TAG;
        end
      end
      PH_INT, PH_FLOAT: advance_arg();
      PH_STRLEN, PH_BLOBLEN: begin
        if (v > lim_payload) fail_with(ERR_PAYLOAD);
        else if (v == 0) advance_arg();
        else begin
          body_left = v[31:0];
          if (frame_phase == PH_STRLEN) frame_phase = PH_STR;
          else frame_phase = PH_BLOB;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void body_step(input logic [7:0] b);
    case (frame_phase) inside
      PH_NAME: begin
        if (body_left > 0) body_left = body_left - 32'd1;
        if (body_left == 0) frame_phase = PH_ARGCOUNT;
      end
      PH_TAG: begin
        case (b)
          TAG_NULL:  advance_arg();
          TAG_BOOL:  frame_phase = PH_BOOL;
          TAG_INT:   frame_phase = PH_INT;
          TAG_FLOAT: frame_phase = PH_FLOAT;
          TAG_STR:   frame_phase = PH_STRLEN;
          TAG_BLOB:  frame_phase = PH_BLOBLEN;
          default:   fail_with(ERR_TAG);
        endcase
      end
      PH_BOOL: advance_arg();
      PH_STR, PH_BLOB: begin
        if (body_left > 0) body_left = body_left - 32'd1;
        if (body_left == 0) advance_arg();
      end
      default: frame_phase = PH_DONE;
    endcase
  endfunction

  function automatic out_item_t label_byte(input in_item_t it);
    out_item_t   r;
    int unsigned flen;
    int unsigned k;
    logic [63:0] v;
    r = '0;
    r.arg_index = arg_num;
    if (frame_phase == PH_DONE) begin
      r.byte_role = PH_DONE;
      if (sticky_err == ERR_NONE) sticky_err = ERR_TRAILING;
    end else begin
      r.byte_role = frame_phase;
      case (frame_phase) inside
        PH_MAGIC, PH_STRLEN, PH_BLOBLEN: flen = 4;
        PH_NAMELEN, PH_ARGCOUNT:         flen = 2;
        PH_INT, PH_FLOAT:                flen = 8;
        default:                         flen = 0;
      endcase
      if (flen != 0) begin
        k = field_pos;
        field_acc = field_acc | (64'(it.in_byte) << (8 * k));
        if (k + 1 >= flen) begin
          v = field_acc;
          r.field_value    = v;
          r.field_complete = 1'b1;
          field_acc = '0;
          field_pos = '0;
          close_field(v);
        end else begin
          field_pos = 3'(k + 1);
        end
      end else begin
        body_step(it.in_byte);
      end
    end
    if (it.end_of_message) begin
      if (frame_phase != PH_DONE && sticky_err == ERR_NONE) sticky_err = ERR_TRUNC;
      r.frame_done = 1'b1;
      r.frame_ok   = (sticky_err == ERR_NONE);
    end
    r.error_code = sticky_err;
    if (it.end_of_message) clear_parser();
    return r;
  endfunction

  // ---------------- directed table helpers ----------------

  function automatic out_item_t want(input logic [3:0] role, input logic [15:0] idx,
                                     input logic [63:0] fv, input logic fc,
                                     input logic done, input logic ok,
                                     input logic [2:0] err);
    out_item_t w;
    w.byte_role      = role;
    w.arg_index      = idx;
    w.field_value    = fv;
    w.field_complete = fc;
    w.frame_done     = done;
    w.frame_ok       = ok;
    w.error_code     = err;
    return w;
  endfunction

  function automatic row_t row_plain(input logic [7:0] b, input logic eom);
    return '{b: b, eom: eom, known: 1'b0, want: '0};
  endfunction

  function automatic row_t row_known(input logic [7:0] b, input logic eom,
                                     input out_item_t w);
    return '{b: b, eom: eom, known: 1'b1, want: w};
  endfunction

  // ---------------- random frame builder ----------------

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly a legal length no bigger than cap, now and then one past the limit or beyond
  function automatic longint unsigned pick_len(input longint unsigned limit,
                                               input longint unsigned field_max,
                                               input int unsigned cap);
    longint unsigned top;
    if ($urandom_range(0, 15) == 0 && limit < field_max) begin
      if ($urandom_range(0, 1) == 0) return limit + 1;
      return limit + 1 + ({32'h0, $urandom()} % (field_max - limit));
    end
    top = (limit < cap) ? limit : cap;
    return $urandom_range(0, 32'(top));
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    frame_bytes.insert(frame_bytes.size(), v);
  endfunction

  function automatic void push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) append_byte(v[8 * i +: 8]);
  endfunction

  function automatic void add_noise(input int n);
    repeat (n) append_byte(8'($urandom()));
  endfunction

  function automatic void build_frame();
    longint unsigned nlen;
    longint unsigned nargs;
    longint unsigned plen;
    logic [7:0]      t;
    logic [63:0]     v;
    frame_bytes.delete();
    if ($urandom_range(0, 24) == 0) push_le({32'h0, $urandom()}, 4);
    else push_le({32'h0, exp_magic}, 4);
    nlen = pick_len(lim_name, 64'hFFFF, 8);
    push_le(nlen, 2);
    if (nlen > lim_name) begin
      add_noise($urandom_range(0, 2));
      return;
    end
    add_noise(int'(nlen));
    nargs = pick_len(lim_args, 64'hFFFF, 5);
    push_le(nargs, 2);
    if (nargs > lim_args) begin
      add_noise($urandom_range(0, 2));
      return;
    end
    repeat (nargs) begin
      if ($urandom_range(0, 29) == 0) begin
        append_byte(8'($urandom_range(6, 255)));
        add_noise($urandom_range(0, 2));
        return;
      end
      t = 8'($urandom_range(TAG_NULL, TAG_BLOB));
      append_byte(t);
      case (t) inside
        TAG_BOOL: add_noise(1);
        TAG_INT, TAG_FLOAT: begin
          case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom(), $urandom()};
          endcase
          push_le(v, 8);
        end
        TAG_STR, TAG_BLOB: begin
          plen = pick_len(lim_payload, 64'hFFFF_FFFF, 8);
          push_le(plen, 4);
          if (plen > lim_payload) begin
            add_noise($urandom_range(0, 2));
            return;
          end
          add_noise(int'(plen));
        end
        default: ;
      endcase
    end
  endfunction

  // ---------------- drivers ----------------

  task automatic send_byte(input logic [7:0] b, input logic eom, input logic known,
                           input out_item_t w);
    int        gap;
    in_item_t  it;
    out_item_t predicted;
    gap = pick_gap();
    it.in_byte        = b;
    it.end_of_message = eom;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = label_byte(it);
    reports_due.insert(reports_due.size(), known ? w : predicted);
    bytes_sent++;
    if (eom) frames_sent++;
  endtask

  task automatic run_frame();
    int r;
    int n;
    build_frame();
    r = $urandom_range(0, 99);
    if (r < 12 && frame_bytes.size() > 1) begin
      n = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
    end else if (r < 20) begin
      add_noise($urandom_range(1, 3));
    end else if (r < 26) begin
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom());
    end else if (r < 30) begin
      frame_bytes.delete();
      add_noise($urandom_range(1, 10));
    end
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAGIC:       exp_magic   = val;
      REG_MAX_NAME:    lim_name    = val[15:0];
      REG_MAX_ARGS:    lim_args    = val[15:0];
      REG_MAX_PAYLOAD: lim_payload = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_set(input int p);
    logic [31:0] m;
    logic [15:0] n;
    logic [15:0] a;
    logic [31:0] pl;
    case (p)
      1: begin
        m = $urandom(); n = '0; a = '0; pl = '0;
      end
      2: begin
        m = '1; n = '1; a = '1; pl = '1;
      end
      3: begin
        m  = '0;
        n  = 16'($urandom_range(1, 8));
        a  = 16'($urandom_range(1, 6));
        pl = $urandom_range(1, 8);
      end
      4: begin
        m = MAGIC_RESET; n = MAX_NAME_RESET; a = MAX_ARGS_RESET; pl = MAX_PAYLOAD_RESET;
      end
      default: begin
        m  = $urandom();
        n  = 16'($urandom_range(0, 12));
        a  = 16'($urandom_range(0, 8));
        pl = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 12);
      end
    endcase
    write_reg(REG_MAGIC, m);
    write_reg(REG_MAX_NAME, {16'h0, n});
    write_reg(REG_MAX_ARGS, {16'h0, a});
    write_reg(REG_MAX_PAYLOAD, pl);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------- result side ----------------

  initial begin : result_sink
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        out_ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      if (mismatches < MAX_REPORTS)
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && out_ready) begin
      if (out_data.frame_done) begin
        if (out_data.frame_ok) frames_ok++;
        else frames_bad++;
      end
      if (reports_due.size() == 0) begin
        if (mismatches < MAX_REPORTS) $error("result item with nothing expected");
        mismatches++;
      end else begin
        w = reports_due.pop_front();
        check_field("byte_role", w.byte_role, out_data.byte_role);
        check_field("arg_index", w.arg_index, out_data.arg_index);
        check_field("field_value", w.field_value, out_data.field_value);
        check_field("field_complete", w.field_complete, out_data.field_complete);
        check_field("frame_done", w.frame_done, out_data.frame_done);
        check_field("frame_ok", w.frame_ok, out_data.frame_ok);
        check_field("error_code", w.error_code, out_data.error_code);
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin : stimulus
    row_t dir_rows [N_DIRECTED];
    int   mark;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    exp_magic   = MAGIC_RESET;
    lim_name    = MAX_NAME_RESET;
    lim_args    = MAX_ARGS_RESET;
    lim_payload = MAX_PAYLOAD_RESET;
    clear_parser();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    dir_rows = '{
      // lone byte ends the message inside the magic
      row_known(8'hFF, 1'b1, want(PH_MAGIC, 16'd0, 64'd0, 1'b0, 1'b1, 1'b0, ERR_TRUNC)),
      // wrong magic
      row_plain(8'h00, 1'b0), row_plain(8'h00, 1'b0), row_plain(8'h00, 1'b0),
      row_known(8'h00, 1'b1, want(PH_MAGIC, 16'd0, 64'd0, 1'b1, 1'b1, 1'b0, ERR_MAGIC)),
      // name length at its largest, over the limit
      row_plain(8'h52, 1'b0), row_plain(8'h50, 1'b0), row_plain(8'h43, 1'b0),
      row_known(8'h31, 1'b0,
                want(PH_MAGIC, 16'd0, 64'h3143_5052, 1'b1, 1'b0, 1'b0, ERR_NONE)),
      row_plain(8'hFF, 1'b0),
      row_known(8'hFF, 1'b1,
                want(PH_NAMELEN, 16'd0, 64'hFFFF, 1'b1, 1'b1, 1'b0, ERR_NAME)),
      // one name byte, null, bool, empty string, then a byte past the end
      row_plain(8'h52, 1'b0), row_plain(8'h50, 1'b0), row_plain(8'h43, 1'b0),
      row_plain(8'h31, 1'b0), row_plain(8'h01, 1'b0), row_plain(8'h00, 1'b0),
      row_plain(8'h80, 1'b0), row_plain(8'h03, 1'b0), row_plain(8'h00, 1'b0),
      row_plain(TAG_NULL, 1'b0), row_plain(TAG_BOOL, 1'b0), row_plain(8'hFF, 1'b0),
      row_plain(TAG_STR, 1'b0), row_plain(8'h00, 1'b0), row_plain(8'h00, 1'b0),
      row_plain(8'h00, 1'b0), row_plain(8'h00, 1'b0),
      row_known(8'h07, 1'b1,
                want(PH_DONE, 16'd3, 64'd0, 1'b0, 1'b1, 1'b0, ERR_TRAILING)),
      // empty name, zero arguments: accepted
      row_plain(8'h52, 1'b0), row_plain(8'h50, 1'b0), row_plain(8'h43, 1'b0),
      row_plain(8'h31, 1'b0), row_plain(8'h00, 1'b0), row_plain(8'h00, 1'b0),
      row_plain(8'h00, 1'b0),
      row_known(8'h00, 1'b1,
                want(PH_ARGCOUNT, 16'd0, 64'd0, 1'b1, 1'b1, 1'b1, ERR_NONE)),
      // unknown tag
      row_plain(8'h52, 1'b0), row_plain(8'h50, 1'b0), row_plain(8'h43, 1'b0),
      row_plain(8'h31, 1'b0), row_plain(8'h00, 1'b0), row_plain(8'h00, 1'b0),
      row_plain(8'h01, 1'b0), row_plain(8'h00, 1'b0),
      row_known(8'h06, 1'b1, want(PH_TAG, 16'd0, 64'd0, 1'b0, 1'b1, 1'b0, ERR_TAG))
    };
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].eom, dir_rows[i].known, dir_rows[i].want);

    for (int p = 1; p <= N_PHASES; p++) begin
      drain();
      program_set(p);
      idle_on = (p % 3) != 0;
      // no sender gaps here, so the long receiver hold backs up the input
      if (p == 3) hold_req = 1'b1;
      mark = bytes_sent;
      while (bytes_sent - mark < ITEMS_PER_SET) run_frame();
    end
    drain();

    $display("Covered %0d bytes in %0d frames over %0d register settings.",
             bytes_sent, frames_sent, N_PHASES + 1);
    $display("Verdicts seen: %0d accepted, %0d rejected.", frames_ok, frames_bad);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/rpcv_pkg.sv
design/rpcv_cfg_regs.sv
design/rpcv_in_stage.sv
design/rpcv_parser.sv
design/rpc_call_frame_validator_top.sv
tb/tb_rpc_call_frame_validator_top.sv
